// ===== src/dwa_pkg.sv =====
// dwa_pkg: widths, register indexes, reset values and divider handshake types
// for the depth window averager. No dependencies.
`timescale 1ns / 1ps

package dwa_pkg;

    localparam int COORD_W    = 12;
    localparam int DEPTH_W    = 16;
    localparam int SIDE_W     = 5;
    localparam int SUM_W      = 24;
    localparam int CNT_W      = 9;
    localparam int AVG_W      = 16;
    localparam int GEO_W      = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int NUM_WIN    = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = '1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIDE_MARGIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_SHIFT = 3'd5;

    localparam logic [COORD_W-1:0] RST_FRAME_WIDTH    = 12'd640;
    localparam logic [COORD_W-1:0] RST_FRAME_HEIGHT   = 12'd480;
    localparam logic [COORD_W-1:0] RST_SIDE_MARGIN    = 12'd40;
    localparam logic [SIDE_W-1:0]  RST_WINDOW_WIDTH   = 5'd9;
    localparam logic [SIDE_W-1:0]  RST_WINDOW_HEIGHT  = 5'd9;
    localparam logic [COORD_W-1:0] RST_VERTICAL_SHIFT = 12'd30;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } dwa_div_req_t;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quotient;
    } dwa_div_rsp_t;

endpackage

// ===== src/dwa_channels.sv =====
// dwa_channels: valid/ready channel interfaces for pixel items, result items
// and configuration writes. Depends on dwa_pkg.
`timescale 1ns / 1ps

interface dwa_pixel_if;
    import dwa_pkg::*;
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [DEPTH_W-1:0] depth_value;
    logic               frame_last;

    modport source (output valid, pixel_row, pixel_col, depth_value, frame_last,
                    input ready);
    modport sink   (input valid, pixel_row, pixel_col, depth_value, frame_last,
                    output ready);
endinterface

interface dwa_result_if;
    import dwa_pkg::*;
    logic             valid;
    logic             ready;
    logic [AVG_W-1:0] left_average;
    logic [AVG_W-1:0] center_average;
    logic [AVG_W-1:0] right_average;

    modport source (output valid, left_average, center_average, right_average,
                    input ready);
    modport sink   (input valid, left_average, center_average, right_average,
                    output ready);
endinterface

interface dwa_cfg_if;
    import dwa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/dwa_divider.sv =====
// dwa_divider: restoring divider, one quotient bit per cycle, sum / count.
// Depends on dwa_pkg.
`timescale 1ns / 1ps

module dwa_divider
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dwa_pkg::dwa_div_req_t req,
    output dwa_pkg::dwa_div_rsp_t rsp
);
    import dwa_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [CNT_W-1:0]  rem_reg,   rem_next;
    logic [SUM_W-1:0]  quo_reg,   quo_next;
    logic [CNT_W-1:0]  div_reg,   div_next;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W+1:0]  diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        diff      = {1'b0, rem_shift} - {2'b0, div_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (diff[CNT_W+1])
            begin
                rem_next = rem_shift[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    // sum <= count * 65535 once saturation is accounted for, so 16 bits hold it
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg[AVG_W-1:0];

endmodule

// ===== src/depth_window_average.sv =====
// depth_window_average: top level, window geometry, accumulators and sequencer.
// Depends on dwa_pkg, dwa_channels and dwa_divider.
`timescale 1ns / 1ps

// Accumulates nonzero depth samples falling in three equal windows (left,
// centre, right) at one height of a streamed frame and, on the pixel marked
// frame_last, returns the three truncated means and clears the sums. A pixel
// is taken in, then goes once per window through the shared compare-and-
// accumulate unit. After the last pixel of a frame the three 24-step
// divisions run on the single shared divider and the result register is
// loaded; it then waits for the sink without holding up the next frame's
// pixels. Configuration writes are always taken.
module depth_window_average
#(
    parameter int MAX_WINDOW_SIDE = 16
)
(
    input  logic clk,
    input  logic rst_n,
    dwa_pixel_if.sink    pixel,
    dwa_result_if.source result,
    dwa_cfg_if.sink      cfg
);
    import dwa_pkg::*;

    localparam int SIDE_CAP = (MAX_WINDOW_SIDE > 31) ? 31 : MAX_WINDOW_SIDE;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ACC      = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_OUT      = 3'd4;

    localparam logic [1:0] WIN_LEFT   = 2'd0;
    localparam logic [1:0] WIN_CENTRE = 2'd1;
    localparam logic [1:0] WIN_RIGHT  = 2'd2;

    // configuration
    logic [COORD_W-1:0] frame_width_reg;
    logic [COORD_W-1:0] frame_height_reg;
    logic [COORD_W-1:0] side_margin_reg;
    logic [SIDE_W-1:0]  window_width_reg;
    logic [SIDE_W-1:0]  window_height_reg;
    logic [COORD_W-1:0] vertical_shift_reg;

    // sequencer
    logic [2:0] state_reg, state_next;
    logic [1:0] win_reg,   win_next;

    // captured pixel
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               last_reg;

    logic [SUM_W-1:0] sums_reg   [NUM_WIN];
    logic [CNT_W-1:0] counts_reg [NUM_WIN];
    logic [AVG_W-1:0] avg_reg    [NUM_WIN];

    logic             out_valid_reg;
    logic [AVG_W-1:0] out_left_reg;
    logic [AVG_W-1:0] out_centre_reg;
    logic [AVG_W-1:0] out_right_reg;

    logic pixel_take;
    logic out_load;

    // geometry
    logic [SIDE_W-1:0]       win_w;
    logic [SIDE_W-1:0]       win_h;
    logic signed [GEO_W-1:0] top_s;
    logic signed [GEO_W-1:0] bottom_s;
    logic signed [GEO_W-1:0] cols_minus_w;
    logic signed [GEO_W-1:0] left_sel;
    logic signed [GEO_W-1:0] row_s;
    logic signed [GEO_W-1:0] col_s;
    logic                    row_hit;
    logic                    col_hit;
    logic                    win_hit;

    logic [SUM_W:0]   sum_add;
    logic [SUM_W-1:0] sum_sat;

    dwa_div_req_t div_req;
    dwa_div_rsp_t div_rsp;

    assign pixel_take = pixel.valid && pixel.ready;
    assign pixel.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= RST_FRAME_WIDTH;
            frame_height_reg   <= RST_FRAME_HEIGHT;
            side_margin_reg    <= RST_SIDE_MARGIN;
            window_width_reg   <= RST_WINDOW_WIDTH;
            window_height_reg  <= RST_WINDOW_HEIGHT;
            vertical_shift_reg <= RST_VERTICAL_SHIFT;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:    frame_width_reg    <= cfg.data;
                REG_FRAME_HEIGHT:   frame_height_reg   <= cfg.data;
                REG_SIDE_MARGIN:    side_margin_reg    <= cfg.data;
                REG_WINDOW_WIDTH:   window_width_reg   <= cfg.data[SIDE_W-1:0];
                REG_WINDOW_HEIGHT:  window_height_reg  <= cfg.data[SIDE_W-1:0];
                REG_VERTICAL_SHIFT: vertical_shift_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // window geometry; a negative top needs no clip as rows are never negative
    always_comb
    begin
        win_w = (window_width_reg > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP)
                                                        : window_width_reg;
        win_h = (window_height_reg > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP)
                                                         : window_height_reg;
        top_s    = $signed({3'b0, frame_height_reg[COORD_W-1:1]})
                 - $signed({2'b0, vertical_shift_reg});
        bottom_s = top_s + $signed({{(GEO_W-SIDE_W){1'b0}}, win_h});
        cols_minus_w = $signed({2'b0, frame_width_reg})
                     - $signed({{(GEO_W-SIDE_W){1'b0}}, win_w});

        case (win_reg)
            WIN_LEFT:   left_sel = $signed({2'b0, side_margin_reg});
            // halve, rounding toward zero
            WIN_CENTRE: left_sel = (cols_minus_w
                                    + $signed({{(GEO_W-1){1'b0}}, cols_minus_w[GEO_W-1]}))
                                   >>> 1;
            WIN_RIGHT:  left_sel = cols_minus_w - $signed({2'b0, side_margin_reg});
            default:    left_sel = '0;
        endcase

        row_s = $signed({2'b0, row_reg});
        col_s = $signed({2'b0, col_reg});

        row_hit = (row_reg < frame_height_reg) && (row_s >= top_s) && (row_s < bottom_s);
        col_hit = (col_reg < frame_width_reg) && (col_s >= left_sel)
               && (col_s < left_sel + $signed({{(GEO_W-SIDE_W){1'b0}}, win_w}));
        win_hit = (depth_reg != '0) && row_hit && col_hit
               && (counts_reg[win_reg] != COUNT_MAX);

        sum_add = {1'b0, sums_reg[win_reg]} + {{(SUM_W+1-DEPTH_W){1'b0}}, depth_reg};
        sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        win_next   = win_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (pixel_take)
                begin
                    state_next = S_ACC;
                    win_next   = WIN_LEFT;
                end
            end
            S_ACC:
            begin
                if (win_reg == WIN_RIGHT)
                begin
                    win_next   = WIN_LEFT;
                    state_next = last_reg ? S_DIV_GO : S_IDLE;
                end
                else
                begin
                    win_next = win_reg + 1'b1;
                end
            end
            S_DIV_GO:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (win_reg == WIN_RIGHT)
                    begin
                        state_next = S_OUT;
                        win_next   = WIN_LEFT;
                    end
                    else
                    begin
                        state_next = S_DIV_GO;
                        win_next   = win_reg + 1'b1;
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                win_next   = WIN_LEFT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WIN_LEFT;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_WIN; k++)
            begin
                sums_reg[k]   <= '0;
                counts_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            win_reg   <= win_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            if (state_reg == S_ACC && win_hit)
            begin
                sums_reg[win_reg]   <= sum_sat;
                counts_reg[win_reg] <= counts_reg[win_reg] + 1'b1;
            end
            else if (state_reg == S_DIV_WAIT && div_rsp.done)
            begin
                sums_reg[win_reg]   <= '0;
                counts_reg[win_reg] <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_take)
        begin
            row_reg   <= pixel.pixel_row;
            col_reg   <= pixel.pixel_col;
            depth_reg <= pixel.depth_value;
            last_reg  <= pixel.frame_last;
        end
        if (state_reg == S_DIV_WAIT && div_rsp.done)
            avg_reg[win_reg] <= (counts_reg[win_reg] == '0) ? '0 : div_rsp.quotient;
        if (out_load)
        begin
            out_left_reg   <= avg_reg[WIN_LEFT];
            out_centre_reg <= avg_reg[WIN_CENTRE];
            out_right_reg  <= avg_reg[WIN_RIGHT];
        end
    end

    assign div_req.start    = (state_reg == S_DIV_GO);
    assign div_req.dividend = sums_reg[win_reg];
    assign div_req.divisor  = counts_reg[win_reg];

    dwa_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign result.valid          = out_valid_reg;
    assign result.left_average   = out_left_reg;
    assign result.center_average = out_centre_reg;
    assign result.right_average  = out_right_reg;

    a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> $past(state_reg == S_DIV_WAIT) || $past(state_reg == S_OUT))
        else $error("result loaded without a completed division pass");

    a_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside the wait state");

    a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> counts_reg[WIN_LEFT] == '0 && counts_reg[WIN_CENTRE] == '0
                     && counts_reg[WIN_RIGHT] == '0 && sums_reg[WIN_LEFT] == '0
                     && sums_reg[WIN_CENTRE] == '0 && sums_reg[WIN_RIGHT] == '0)
        else $error("accumulators not cleared at frame end");

endmodule

// ===== tb/sv/dwa_window_checker.sv =====
// dwa_window_checker: watches the pixel, result and configuration channels of
// the depth window averager, predicts each frame's three averages and compares.
// Depends on dwa_pkg and dwa_channels.
`timescale 1ns / 1ps

module dwa_window_checker
#(
    parameter int MAX_WINDOW_SIDE = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    dwa_pixel_if  pix,
    dwa_result_if res,
    dwa_cfg_if    cfg,
    output int    mismatches,
    output int    pending
);
    import dwa_pkg::*;

    typedef logic [NUM_WIN-1:0][AVG_W-1:0] avg_set_t;

    logic [COORD_W-1:0] cols_q;
    logic [COORD_W-1:0] rows_q;
    logic [COORD_W-1:0] margin_q;
    logic [COORD_W-1:0] vshift_q;
    logic [SIDE_W-1:0]  win_w_q;
    logic [SIDE_W-1:0]  win_h_q;
    logic [SUM_W-1:0]   win_sum [NUM_WIN];
    logic [CNT_W-1:0]   win_cnt [NUM_WIN];
    avg_set_t           frame_avg_q [$];
    string              field_name [NUM_WIN] = '{"left_average", "center_average",
                                                 "right_average"};

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_FRAME_WIDTH:    cols_q   = val;
            REG_FRAME_HEIGHT:   rows_q   = val;
            REG_SIDE_MARGIN:    margin_q = val;
            REG_WINDOW_WIDTH:   win_w_q  = val[SIDE_W-1:0];
            REG_WINDOW_HEIGHT:  win_h_q  = val[SIDE_W-1:0];
            REG_VERTICAL_SHIFT: vshift_q = val;
            default: ;
        endcase
    endtask

    // accumulate one pixel; on the last pixel of a frame queue the averages
    task automatic take_pixel(input logic [COORD_W-1:0] row,
                              input logic [COORD_W-1:0] col,
                              input logic [DEPTH_W-1:0] depth,
                              input logic               last);
        int          w;
        int          h;
        int          top;
        int          bottom;
        int          r;
        int          c;
        int          left_edge [NUM_WIN];
        logic [31:0] acc;
        avg_set_t    avg;
        w = (win_w_q > MAX_WINDOW_SIDE) ? MAX_WINDOW_SIDE : int'(win_w_q);
        h = (win_h_q > MAX_WINDOW_SIDE) ? MAX_WINDOW_SIDE : int'(win_h_q);
        top = int'(rows_q) / 2 - int'(vshift_q);
        bottom = top + h;
        if (top < 0)
            top = 0;
        left_edge[0] = int'(margin_q);
        left_edge[1] = (int'(cols_q) - w) / 2;
        left_edge[2] = int'(cols_q) - w - int'(margin_q);
        r = int'(row);
        c = int'(col);
        if (depth != '0 && r < int'(rows_q) && c < int'(cols_q) && r >= top && r < bottom)
        begin
            for (int k = 0; k < NUM_WIN; k++)
            begin
                if (c >= left_edge[k] && c < left_edge[k] + w && win_cnt[k] != COUNT_MAX)
                begin
                    win_cnt[k] = win_cnt[k] + 1'b1;
                    acc = 32'(win_sum[k]) + 32'(depth);
                    win_sum[k] = (acc > 32'(SUM_MAX)) ? SUM_MAX : acc[SUM_W-1:0];
                end
            end
        end
        if (last)
        begin
            for (int k = 0; k < NUM_WIN; k++)
            begin
                avg[k] = (win_cnt[k] == '0) ? '0
                                            : AVG_W'(32'(win_sum[k]) / 32'(win_cnt[k]));
                win_sum[k] = '0;
                win_cnt[k] = '0;
            end
            frame_avg_q = {frame_avg_q, avg};
        end
    endtask

    task automatic check_result;
        avg_set_t got;
        avg_set_t want;
        got = {res.right_average, res.center_average, res.left_average};
        if (frame_avg_q.size() == 0)
        begin
            report($sformatf("result %0d/%0d/%0d with no frame pending",
                             got[0], got[1], got[2]));
        end
        else
        begin
            want = frame_avg_q.pop_front();
            for (int k = 0; k < NUM_WIN; k++)
            begin
                if (got[k] != want[k])
                    report($sformatf("%s got %0d expected %0d",
                                     field_name[k], got[k], want[k]));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_q   = RST_FRAME_WIDTH;
            rows_q   = RST_FRAME_HEIGHT;
            margin_q = RST_SIDE_MARGIN;
            win_w_q  = RST_WINDOW_WIDTH;
            win_h_q  = RST_WINDOW_HEIGHT;
            vshift_q = RST_VERTICAL_SHIFT;
            for (int k = 0; k < NUM_WIN; k++)
            begin
                win_sum[k] = '0;
                win_cnt[k] = '0;
            end
            frame_avg_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                write_reg(cfg.index, cfg.data);
            if (pix.valid && pix.ready)
                take_pixel(pix.pixel_row, pix.pixel_col, pix.depth_value, pix.frame_last);
            if (res.valid && res.ready)
                check_result();
            pending = frame_avg_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_depth_window_average.sv =====
// tb_depth_window_average: drives pixel frames and configuration phases into
// depth_window_average, paces the result side and gives the verdict.
// Depends on dwa_pkg, dwa_channels, depth_window_average and dwa_window_checker.
`timescale 1ns / 1ps

module tb_depth_window_average;
    import dwa_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_SIDE      = 16;
    localparam int ITEM_TARGET   = 1300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 120;
    localparam int LONG_HOLD     = 600;
    localparam int HOLD_PHASE    = 6;
    localparam int HEAVY_PHASE   = 4;
    localparam int HEAVY_ITEMS   = 530;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   mismatch_count;
    int   pending_count;
    int   sent_count  = 0;
    int   burst_left  = 1;
    int   cycle_count = 0;
    bit   hold_go     = 1'b0;

    int   cur_cols;
    int   cur_rows;
    int   cur_margin;
    int   cur_ww;
    int   cur_wh;
    int   cur_vshift;
    int   geo_w;
    int   geo_h;
    int   geo_top;
    int   geo_left [NUM_WIN];

    logic [CFG_IDX_W-1:0] reg_order [6] = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT,
                                            REG_SIDE_MARGIN, REG_WINDOW_WIDTH,
                                            REG_WINDOW_HEIGHT, REG_VERTICAL_SHIFT};

    dwa_pixel_if  pix_if ();
    dwa_result_if res_if ();
    dwa_cfg_if    cfg_if ();

    depth_window_average #(.MAX_WINDOW_SIDE(MAX_SIDE)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pix_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    dwa_window_checker #(.MAX_WINDOW_SIDE(MAX_SIDE)) u_window_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix        (pix_if),
        .res        (res_if),
        .cfg        (cfg_if),
        .mismatches (mismatch_count),
        .pending    (pending_count)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pick_extent();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, 64);
            1:       return $urandom_range(16, 700);
            default: return $urandom_range(1, 4095);
        endcase
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(17, 31);
            default: return $urandom_range(1, 16);
        endcase
    endfunction

    // offer one item from a falling edge, return at a falling edge after it is taken
    task automatic send_pixel(input int row, input int col, input int depth,
                              input bit last);
        pix_if.valid       <= 1'b1;
        pix_if.pixel_row   <= COORD_W'(row);
        pix_if.pixel_col   <= COORD_W'(col);
        pix_if.depth_value <= DEPTH_W'(depth);
        pix_if.frame_last  <= last;
        do
            @(posedge clk);
        while (!pix_if.ready);
        sent_count++;
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 250 : $urandom_range(1, 20);
        end
    endtask

    task automatic settle();
        pix_if.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly pixels aimed at a window edge or interior, some noise
    task automatic send_frame(input int n);
        int k;
        int r;
        int c;
        int row_lo;
        int span;
        int depth;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, NUM_WIN - 1);
            row_lo = (geo_top < 0) ? 0 : geo_top;
            span = geo_top + geo_h - row_lo;
            if (span < 0)
                span = 0;
            r = row_lo - 1 + int'($urandom_range(0, span + 1));
            c = geo_left[k] - 1 + int'($urandom_range(0, geo_w + 1));
            case ($urandom_range(0, 7))
                0:       depth = 16'hFFFF;
                1:       depth = 1;
                default: depth = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 9))
                7:
                begin
                    r = $urandom_range(0, 4095);
                    c = $urandom_range(0, 4095);
                end
                8:
                begin
                    r = $urandom_range(0, cur_rows - 1);
                    c = $urandom_range(0, cur_cols - 1);
                end
                9:       depth = 0;
                default: ;
            endcase
            send_pixel(r, c, depth, i == n - 1);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        int reg_val [6];
        pix_if.valid       = 1'b0;
        pix_if.pixel_row   = '0;
        pix_if.pixel_col   = '0;
        pix_if.depth_value = '0;
        pix_if.frame_last  = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_FRAME_WIDTH;
        cfg_if.data        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: rows 210..218, columns 40..48, 315..323, 591..599
        send_pixel(210, 40, 65535, 1'b0);
        send_pixel(218, 48, 1, 1'b0);
        send_pixel(210, 315, 1000, 1'b0);
        send_pixel(218, 323, 2000, 1'b0);
        send_pixel(214, 591, 65535, 1'b0);
        send_pixel(214, 599, 3, 1'b0);
        send_pixel(209, 40, 500, 1'b0);
        send_pixel(219, 44, 500, 1'b0);
        send_pixel(214, 39, 500, 1'b0);
        send_pixel(214, 49, 500, 1'b0);
        send_pixel(214, 44, 0, 1'b0);
        send_pixel(4095, 4095, 65535, 1'b0);
        send_pixel(0, 4095, 65535, 1'b0);
        send_pixel(4095, 0, 65535, 1'b0);
        send_pixel(214, 320, 7, 1'b1);
        send_pixel(0, 0, 0, 1'b1);
        send_pixel(4095, 4095, 9, 1'b1);
        send_pixel(214, 600, 12345, 1'b0);
        send_pixel(214, 595, 12345, 1'b1);
        settle();

        for (phase = 0; sent_count < ITEM_TARGET; phase++)
        begin
            case (phase)
                0:       reg_val = '{4095, 4095, 0, 16, 16, 0};
                1:       reg_val = '{1, 1, 0, 1, 1, 0};
                2:       reg_val = '{64, 40, 4095, 31, 0, 4095};
                3:       reg_val = '{9, 60, 0, 31, 31, 35};
                4:       reg_val = '{16, 32, 0, 16, 16, 0};
                default:
                begin
                    reg_val[0] = pick_extent();
                    reg_val[1] = pick_extent();
                    reg_val[2] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, reg_val[0] / 3);
                    reg_val[3] = pick_side();
                    reg_val[4] = pick_side();
                    reg_val[5] = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, reg_val[1] / 2 + 8);
                end
            endcase
            for (int i = 0; i < 6; i++)
            begin
                cfg_if.valid <= 1'b1;
                cfg_if.index <= reg_order[i];
                cfg_if.data  <= CFG_DATA_W'(reg_val[i]);
                do
                    @(posedge clk);
                while (!cfg_if.ready);
                @(negedge clk);
            end
            cfg_if.valid <= 1'b0;

            cur_cols   = reg_val[0];
            cur_rows   = reg_val[1];
            cur_margin = reg_val[2];
            cur_ww     = reg_val[3];
            cur_wh     = reg_val[4];
            cur_vshift = reg_val[5];
            geo_w       = (cur_ww > MAX_SIDE) ? MAX_SIDE : cur_ww;
            geo_h       = (cur_wh > MAX_SIDE) ? MAX_SIDE : cur_wh;
            geo_top     = cur_rows / 2 - cur_vshift;
            geo_left[0] = cur_margin;
            geo_left[1] = (cur_cols - geo_w) / 2;
            geo_left[2] = cur_cols - geo_w - cur_margin;

            if (phase == HEAVY_PHASE)
            begin
                // windows overlap on one 16x16 patch; drive count and sum to saturation
                for (int i = 0; i < HEAVY_ITEMS; i++)
                    send_pixel(16 + $urandom_range(0, 15), $urandom_range(0, 15),
                               16'hFFFF, i == HEAVY_ITEMS - 1);
                send_frame($urandom_range(1, 24));
            end
            else if (phase == HOLD_PHASE)
            begin
                // short frames under a held sink so results back up and stall the input
                hold_go = 1'b1;
                repeat (4)
                    send_frame($urandom_range(1, 4));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_frame($urandom_range(1, 24));
            end
            settle();
        end

        if (mismatch_count == 0)
            $display("tb_depth_window_average OK");
        else
            $display("tb_depth_window_average NOT OK");
        $finish;
    end

    initial
    begin : sink_pacing
        int mode;
        int mode_left;
        bit held;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && hold_go)
            begin
                // long back-pressure so the block fills and stalls its input
                held = 1'b1;
                res_if.ready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(negedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_depth_window_average NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/dwa_pkg.sv
src/dwa_channels.sv
src/dwa_divider.sv
src/depth_window_average.sv
tb/sv/dwa_window_checker.sv
tb/sv/tb_depth_window_average.sv
